FILE: hw/rtl/htfd_pkg.sv
// Shared constants and the CRC-8 byte update for the sensor frame decoder.
// No dependencies.
`timescale 1ns / 1ps

package htfd_pkg;

	localparam int unsigned FRAME_BYTES = 7;
	localparam int unsigned STORE_DEPTH = FRAME_BYTES - 1;
	localparam int unsigned POS_W       = 3;

	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h31;

	localparam logic [13:0] HUM_SCALE  = 14'd10000;
	localparam logic [14:0] TEMP_SCALE = 15'd20000;
	localparam logic [14:0] TEMP_BIAS  = 15'd5000;

	localparam int unsigned RAW_W   = 20;
	localparam int unsigned HPROD_W = RAW_W + 14;
	localparam int unsigned TPROD_W = RAW_W + 15;

	typedef logic [POS_W-1:0] pos_t;

	// MSB-first CRC-8 update over one byte, no final xor
	function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

FILE: hw/rtl/humidity_temperature_frame_decoder_top.sv
// Sensor reply frame decoder: byte assembly, CRC-8 check, raw unpack and scaling.
// Depends on htfd_pkg.
`timescale 1ns / 1ps

// After the transfer of the CRC byte a result passes the unpack register (loaded at
// that edge), then the multiplier register, then the output register.
// Throughput: one byte per cycle while rx_ready is high; the byte-wise CRC update
// and the two 20-bit constant multipliers each fit between registers.
// Reset: arst_n clears the byte position, loads the CRC with its initial
// value and empties every pipeline stage; the frame store is not cleared.
module humidity_temperature_frame_decoder_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rx_valid,
	output logic                      rx_ready,
	input  logic [7:0]                rx_byte,
	input  logic                      frame_start,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic [7:0]                status_byte,
	output logic [19:0]               raw_humidity,
	output logic [19:0]               raw_temperature,
	output logic [13:0]               humidity_centi,
	output logic signed [14:0]        temperature_centi,
	output logic                      crc_ok
);
	import htfd_pkg::*;

	localparam pos_t LAST_POS = pos_t'(STORE_DEPTH);

	pos_t       pos_q;
	logic [7:0] crc_q;
	logic [7:0] store_q [STORE_DEPTH];

	logic             v_s1, v_s2;
	logic [7:0]       status_s1, status_s2;
	logic [RAW_W-1:0] rh_s1, rt_s1, rh_s2, rt_s2;
	logic             ok_s1, ok_s2;
	logic [HPROD_W-1:0] hprod_s2;
	logic [TPROD_W-1:0] tprod_s2;

	logic rdy_out, rdy_s2, rdy_s1;
	logic take, emit;

	assign rdy_out  = !res_valid || res_ready;
	assign rdy_s2   = !v_s2 || rdy_out;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign rx_ready = rdy_s1;
	assign take     = rx_valid && rx_ready;
	assign emit     = take && !frame_start && (pos_q == LAST_POS);

	// frame assembly and running CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= CRC_INIT;
		end else if (take) begin
			if (frame_start) begin
				pos_q <= pos_t'(1);
				crc_q <= crc8_feed(CRC_INIT, rx_byte);
			end else if (pos_q == '0 || pos_q > LAST_POS) begin
				pos_q <= '0;
			end else if (pos_q < LAST_POS) begin
				pos_q <= pos_q + pos_t'(1);
				crc_q <= crc8_feed(crc_q, rx_byte);
			end else begin
				pos_q <= '0;
				crc_q <= CRC_INIT;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < STORE_DEPTH; i++) begin
			if (take) begin
				if (frame_start && i == 0) begin
					store_q[i] <= rx_byte;
				end else if (!frame_start && pos_q != '0 && pos_q < LAST_POS
						&& pos_q == pos_t'(i)) begin
					store_q[i] <= rx_byte;
				end
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= emit;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_out) res_valid <= v_s2;
		end
	end

	// unpack on the CRC byte
	always_ff @(posedge clk) begin
		if (rdy_s1 && emit) begin
			status_s1 <= store_q[0];
			rh_s1     <= {store_q[1], store_q[2], store_q[3][7:4]};
			rt_s1     <= {store_q[3][3:0], store_q[4], store_q[5]};
			ok_s1     <= (crc_q == rx_byte);
		end
	end

	// scale multipliers
	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			status_s2 <= status_s1;
			rh_s2     <= rh_s1;
			rt_s2     <= rt_s1;
			ok_s2     <= ok_s1;
			hprod_s2  <= HPROD_W'(rh_s1) * HPROD_W'(HUM_SCALE);
			tprod_s2  <= TPROD_W'(rt_s1) * TPROD_W'(TEMP_SCALE);
		end
	end

	// truncate, remove the temperature offset, hold for the transfer
	always_ff @(posedge clk) begin
		if (rdy_out && v_s2) begin
			status_byte       <= status_s2;
			raw_humidity      <= rh_s2;
			raw_temperature   <= rt_s2;
			crc_ok            <= ok_s2;
			humidity_centi    <= hprod_s2[HPROD_W-1:RAW_W];
			temperature_centi <= $signed(tprod_s2[TPROD_W-1:RAW_W] - TEMP_BIAS);
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LAST_POS)
		else $error("byte position beyond the CRC byte");

	a_crc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q == '0 |-> crc_q == CRC_INIT)
		else $error("CRC not at initial value while idle");

	a_emit_fill: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> v_s1)
		else $error("CRC byte transfer did not fill the unpack stage");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid && $stable(crc_ok))
		else $error("pending result overwritten");

endmodule
